[rtl/core/png_scanline_unfilter_assert.svh]
// ----------------------------------------------------------------------------
// png scanline unfilter assertion macros
// Shorthand for the concurrent checks that are clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PSU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("png scanline unfilter: check failed");

// consequent checked in the cycle after the antecedent
`define PSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("png scanline unfilter: check failed");

`endif

[rtl/core/psu_pkg.sv]
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types and constants of the png scanline unfilter.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

   localparam int unsigned MAX_ROW_BYTES_DEF   = 8192;
   localparam int unsigned MAX_PIXEL_BYTES_DEF = 8;

   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned ROW_BYTES_W  = 14;
   localparam int unsigned STRIDE_W     = 4;
   localparam int unsigned CSR_ADDR_W   = 1;
   localparam int unsigned CSR_DATA_W   = 14;
   localparam int unsigned REQ_USER_W   = 2;

   typedef logic [CSR_ADDR_W-1:0] csr_index_type;

   localparam csr_index_type CSR_ROW_BYTES    = 1'b0;
   localparam csr_index_type CSR_PIXEL_STRIDE = 1'b1;

   // tuser bit positions on the request side
   localparam int unsigned REQ_USER_FILTER = 0;
   localparam int unsigned REQ_USER_CLEAR  = 1;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   // unknown filter codes fall back to none
   function automatic filter_type decode_filter(input logic [BYTE_W-1:0] code);
      filter_type kind;
      kind = FILT_NONE;
      if (code <= BYTE_W'(FILT_PAETH)) begin
         kind = filter_type'(code[2:0]);
      end
      return kind;
   endfunction

endpackage

`default_nettype wire

[rtl/core/png_scanline_unfilter.sv]
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG filter reconstruction of inflated bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
// Requests are inflated stream bytes; a filter byte (tuser bit 0) opens a row
// and gives no response, every data byte gives one reconstructed byte with
// tlast on the row's final byte. The block sustains one request per clock
// unless the response side stalls: the byte above is read from the row memory
// in the accept cycle, and the compute stage then computes the prediction,
// writes the result back into that same row memory entry and loads the
// response register. A write/read bypass in the row memory covers one-byte
// rows, where a byte reads the entry that the byte ahead of it writes in that
// cycle. The row memory needs no clearing pass after reset: clear_above on a
// filter byte makes the previous row read as zeros. The user must write row
// length and pixel stride only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "png_scanline_unfilter_assert.svh"

module png_scanline_unfilter #(
   parameter int unsigned MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
   parameter int unsigned MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [psu_pkg::BYTE_W-1:0]      req_tdata,   // byte_value
   input  wire logic [psu_pkg::REQ_USER_W-1:0]  req_tuser,   // is_filter_byte, clear_above
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [psu_pkg::BYTE_W-1:0]      rsp_tdata,   // pixel_byte
   output logic                                 rsp_tlast,
   input  wire logic                            csr_wen,
   input  wire psu_pkg::csr_index_type          csr_index,
   input  wire logic [psu_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import psu_pkg::*;

   localparam int unsigned COL_W = $clog2(MAX_ROW_BYTES);
   localparam int unsigned LEN_W = (COL_W + 1 > ROW_BYTES_W) ? COL_W + 1 : ROW_BYTES_W;
   localparam int unsigned SEL_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   // configuration
   logic [ROW_BYTES_W-1:0] row_bytes_ff, row_bytes_in;
   logic [STRIDE_W-1:0]    stride_ff, stride_in;

   // accept stage
   logic [COL_W-1:0]       col_ff, col_in;

   // compute stage
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_filter_ff, s1_filter_in;
   logic                   s1_clr_ff, s1_clr_in;
   logic                   s1_last_ff, s1_last_in;
   logic [BYTE_W-1:0]      s1_byte_ff, s1_byte_in;
   logic [COL_W-1:0]       s1_col_ff, s1_col_in;

   filter_type             kind_ff, kind_in;
   logic                   above_valid_ff, above_valid_in;
   logic [BYTE_W-1:0]      left_ff [MAX_PIXEL_BYTES];
   logic [BYTE_W-1:0]      left_in [MAX_PIXEL_BYTES];
   logic [BYTE_W-1:0]      upleft_ff [MAX_PIXEL_BYTES];
   logic [BYTE_W-1:0]      upleft_in [MAX_PIXEL_BYTES];

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [LEN_W-1:0]       row_ext;
   logic [LEN_W-1:0]       max_len;
   logic [LEN_W-1:0]       eff_len;
   logic [LEN_W-1:0]       col_next_ext;
   logic                   last0;
   logic [STRIDE_W-1:0]    eff_stride;
   logic [SEL_W-1:0]       sel;

   logic                   req_accept;
   logic                   req_is_filter;
   logic                   req_row_end;
   logic                   out_free;
   logic                   s1_fire;
   logic                   s1_data_fire;
   logic                   s1_holds_data;

   logic [BYTE_W-1:0]      mem_rd_data;
   logic [BYTE_W-1:0]      a_byte;
   logic [BYTE_W-1:0]      b_byte;
   logic [BYTE_W-1:0]      c_byte;
   logic [BYTE_W-1:0]      pred;
   logic [BYTE_W-1:0]      res;

   // handshake
   assign req_is_filter = req_tuser[REQ_USER_FILTER];
   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign s1_fire       = s1_valid_ff && (s1_filter_ff || out_free);
   assign s1_data_fire  = s1_fire && !s1_filter_ff;
   assign s1_holds_data = s1_valid_ff && !s1_filter_ff;
   assign req_tready    = !s1_valid_ff || s1_fire;
   assign req_accept    = req_tvalid && req_tready;
   assign req_row_end   = req_accept && !req_is_filter && last0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // clamped row length and stride
   always_comb begin
      row_ext = LEN_W'(row_bytes_ff);
      max_len = LEN_W'(MAX_ROW_BYTES);
      if (row_ext == '0) begin
         eff_len = LEN_W'(1);
      end else if (row_ext > max_len) begin
         eff_len = max_len;
      end else begin
         eff_len = row_ext;
      end
      col_next_ext = LEN_W'(col_ff) + LEN_W'(1);
      last0        = col_next_ext >= eff_len;

      if (stride_ff == '0) begin
         eff_stride = STRIDE_W'(1);
      end else if (stride_ff > STRIDE_W'(MAX_PIXEL_BYTES)) begin
         eff_stride = STRIDE_W'(MAX_PIXEL_BYTES);
      end else begin
         eff_stride = stride_ff;
      end
      sel = SEL_W'(eff_stride - STRIDE_W'(1));
   end

   psu_row_mem #(
      .DEPTH  (MAX_ROW_BYTES),
      .ADDR_W (COL_W)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (s1_data_fire),
      .wr_addr (s1_col_ff),
      .wr_data (res),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (mem_rd_data)
   );

   assign a_byte = left_ff[sel];
   assign c_byte = upleft_ff[sel];
   assign b_byte = above_valid_ff ? mem_rd_data : '0;

   psu_predict u_predict (
      .kind        (kind_ff),
      .left_byte   (a_byte),
      .above_byte  (b_byte),
      .corner_byte (c_byte),
      .pred        (pred)
   );

   assign res = s1_byte_ff + pred;

   always_comb begin
      row_bytes_in = row_bytes_ff;
      stride_in    = stride_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_ROW_BYTES:    row_bytes_in = ROW_BYTES_W'(csr_wdata);
            CSR_PIXEL_STRIDE: stride_in    = STRIDE_W'(csr_wdata);
            default:          row_bytes_in = row_bytes_ff;
         endcase
      end

      // accept stage: column tracking
      col_in       = col_ff;
      s1_valid_in  = s1_valid_ff;
      s1_filter_in = s1_filter_ff;
      s1_clr_in    = s1_clr_ff;
      s1_last_in   = s1_last_ff;
      s1_byte_in   = s1_byte_ff;
      s1_col_in    = s1_col_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      if (req_accept) begin
         s1_filter_in = req_is_filter;
         s1_clr_in    = req_tuser[REQ_USER_CLEAR];
         s1_last_in   = last0;
         s1_byte_in   = req_tdata;
         s1_col_in    = col_ff;
         if (req_is_filter || last0) begin
            col_in = '0;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end

      // compute stage: row state and windows
      kind_in        = kind_ff;
      above_valid_in = above_valid_ff;
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
         left_in[i]   = left_ff[i];
         upleft_in[i] = upleft_ff[i];
      end
      if (s1_fire && s1_filter_ff) begin
         kind_in = decode_filter(s1_byte_ff);
         if (s1_clr_ff) begin
            above_valid_in = 1'b0;
         end
         for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            left_in[i]   = '0;
            upleft_in[i] = '0;
         end
      end else if (s1_data_fire) begin
         if (s1_last_ff) begin
            above_valid_in = 1'b1;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
               left_in[i]   = '0;
               upleft_in[i] = '0;
            end
         end else begin
            left_in[0]   = res;
            upleft_in[0] = b_byte;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
               left_in[i]   = left_ff[i-1];
               upleft_in[i] = upleft_ff[i-1];
            end
         end
      end

      // response register
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = s1_data_fire;
      end
      if (s1_data_fire) begin
         rsp_data_in = res;
         rsp_last_in = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff   <= ROW_BYTES_W'(1);
         stride_ff      <= STRIDE_W'(1);
         col_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         kind_ff        <= FILT_NONE;
         above_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            left_ff[i]   <= '0;
            upleft_ff[i] <= '0;
         end
      end else begin
         row_bytes_ff   <= row_bytes_in;
         stride_ff      <= stride_in;
         col_ff         <= col_in;
         s1_valid_ff    <= s1_valid_in;
         kind_ff        <= kind_in;
         above_valid_ff <= above_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            left_ff[i]   <= left_in[i];
            upleft_ff[i] <= upleft_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_filter_ff <= s1_filter_in;
      s1_clr_ff    <= s1_clr_in;
      s1_last_ff   <= s1_last_in;
      s1_byte_ff   <= s1_byte_in;
      s1_col_ff    <= s1_col_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   `PSU_ASSERT_NEXT(a_filter_restarts_row, clock, reset, req_accept && req_is_filter, col_ff == '0)
   `PSU_ASSERT_NEXT(a_last_restarts_row, clock, reset, req_row_end, col_ff == '0)
   `PSU_ASSERT_NEXT(a_stall_holds_item, clock, reset, s1_holds_data && !out_free, s1_holds_data)
   `PSU_ASSERT_NEXT(a_row_end_sets_above, clock, reset, s1_data_fire && s1_last_ff, above_valid_ff)
   `PSU_ASSERT_SAME(a_resp_needs_free_slot, clock, reset, s1_data_fire, out_free)

endmodule

`default_nettype wire

[rtl/core/psu_row_mem.sv]
// ----------------------------------------------------------------------------
// psu_row_mem
// Previous-row byte store: one write port, one registered read port, with a
// bypass when the read hits the entry written in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_row_mem #(
   parameter int unsigned DEPTH  = psu_pkg::MAX_ROW_BYTES_DEF,
   parameter int unsigned ADDR_W = $clog2(psu_pkg::MAX_ROW_BYTES_DEF)
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire logic [psu_pkg::BYTE_W-1:0]  wr_data,
   input  wire logic                        rd_en,
   input  wire logic [ADDR_W-1:0]           rd_addr,
   output logic      [psu_pkg::BYTE_W-1:0]  rd_data
);
   import psu_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_raw_ff;
   logic              byp_hit_ff;
   logic [BYTE_W-1:0] byp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_raw_ff   <= mem[rd_addr];
         byp_hit_ff  <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_hit_ff ? byp_data_ff : rd_raw_ff;

endmodule

`default_nettype wire

[rtl/core/psu_predict.sv]
// ----------------------------------------------------------------------------
// psu_predict
// Filter predictor: none, sub, up, average and paeth from left, above and
// upper-left bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_predict (
   input  wire psu_pkg::filter_type         kind,
   input  wire logic [psu_pkg::BYTE_W-1:0]  left_byte,
   input  wire logic [psu_pkg::BYTE_W-1:0]  above_byte,
   input  wire logic [psu_pkg::BYTE_W-1:0]  corner_byte,
   output logic      [psu_pkg::BYTE_W-1:0]  pred
);
   import psu_pkg::*;

   localparam int unsigned DIFF_W = BYTE_W + 2;

   logic [BYTE_W:0]          avg_sum;
   logic signed [DIFF_W-1:0] da;
   logic signed [DIFF_W-1:0] db;
   logic signed [DIFF_W-1:0] dc;
   logic [DIFF_W-1:0]        pa;
   logic [DIFF_W-1:0]        pb;
   logic [DIFF_W-1:0]        pc;
   logic [BYTE_W-1:0]        paeth_pick;

   always_comb begin
      avg_sum = {1'b0, left_byte} + {1'b0, above_byte};

      da = $signed({2'b00, above_byte}) - $signed({2'b00, corner_byte});
      db = $signed({2'b00, left_byte}) - $signed({2'b00, corner_byte});
      dc = da + db;
      pa = (da < 0) ? DIFF_W'(-da) : DIFF_W'(da);
      pb = (db < 0) ? DIFF_W'(-db) : DIFF_W'(db);
      pc = (dc < 0) ? DIFF_W'(-dc) : DIFF_W'(dc);

      // ties go to left, then above
      if ((pa <= pb) && (pa <= pc)) begin
         paeth_pick = left_byte;
      end else if (pb <= pc) begin
         paeth_pick = above_byte;
      end else begin
         paeth_pick = corner_byte;
      end

      case (kind)
         FILT_SUB:   pred = left_byte;
         FILT_UP:    pred = above_byte;
         FILT_AVG:   pred = avg_sum[BYTE_W:1];
         FILT_PAETH: pred = paeth_pick;
         default:    pred = '0;
      endcase
   end

endmodule

`default_nettype wire

[verif/scanline_checker.sv]
// ----------------------------------------------------------------------------
// scanline_checker
// Watches the request, response and register ports of the png scanline
// unfilter, rebuilds every data byte from its own copy of the row memory and
// pixel windows, and compares each response with the oldest rebuilt byte.
// ----------------------------------------------------------------------------
module scanline_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [psu_pkg::BYTE_W-1:0]     req_tdata,
   input  logic [psu_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [psu_pkg::BYTE_W-1:0]     rsp_tdata,
   input  logic                           rsp_tlast,
   input  logic                           csr_wen,
   input  psu_pkg::csr_index_type         csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             failures,
   output int                             pending
);
   import psu_pkg::*;

   localparam int ROW_CAP = MAX_ROW_BYTES_DEF;
   localparam int PIX_CAP = MAX_PIXEL_BYTES_DEF;
   localparam int COL_W   = $clog2(ROW_CAP);

   typedef struct packed {
      logic [BYTE_W-1:0] pixel_byte;
      logic              last_in_row;
   } rebuilt_byte_type;

   rebuilt_byte_type       rebuilt_q[$];
   rebuilt_byte_type       due;
   logic [BYTE_W-1:0]      prev_row [ROW_CAP];
   logic                   prev_row_valid;
   logic [8*PIX_CAP-1:0]   left_bytes;
   logic [8*PIX_CAP-1:0]   upper_left_bytes;
   logic [COL_W-1:0]       col;
   filter_type             row_filter;
   logic [ROW_BYTES_W-1:0] row_bytes_reg;
   logic [STRIDE_W-1:0]    stride_reg;

   function automatic logic [BYTE_W-1:0] paeth_pick(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b,
                                                    input logic [BYTE_W-1:0] c);
      int pa, pb, pc;
      pa = int'(b) - int'(c);
      pb = int'(a) - int'(c);
      pc = int'(a) + int'(b) - 2 * int'(c);
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      // ties go to left, then above
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
   endfunction

   task automatic take_request(input logic [BYTE_W-1:0] value,
                               input logic [REQ_USER_W-1:0] user);
      int                len, stride;
      logic [BYTE_W-1:0] a, b, c, pred, res;
      logic              last;
      if (user[REQ_USER_FILTER]) begin
         row_filter = (value > BYTE_W'(FILT_PAETH)) ? FILT_NONE : filter_type'(value[2:0]);
         if (user[REQ_USER_CLEAR]) prev_row_valid = 1'b0;
         col = '0;
         left_bytes = '0;
         upper_left_bytes = '0;
         return;
      end
      len = (row_bytes_reg == 0) ? 1 : ((int'(row_bytes_reg) > ROW_CAP) ? ROW_CAP
                                                                        : int'(row_bytes_reg));
      stride = (stride_reg == 0) ? 1 : ((int'(stride_reg) > PIX_CAP) ? PIX_CAP
                                                                    : int'(stride_reg));
      a = BYTE_W'(left_bytes >> (8 * (stride - 1)));
      c = BYTE_W'(upper_left_bytes >> (8 * (stride - 1)));
      b = prev_row_valid ? prev_row[col] : '0;
      case (row_filter)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = BYTE_W'((9'(a) + 9'(b)) >> 1);
         FILT_PAETH: pred = paeth_pick(a, b, c);
         default:    pred = '0;
      endcase
      res = value + pred;
      prev_row[col] = res;
      left_bytes = {left_bytes[8*PIX_CAP-9:0], res};
      upper_left_bytes = {upper_left_bytes[8*PIX_CAP-9:0], b};
      last = (int'(col) + 1) >= len;
      if (last) begin
         prev_row_valid = 1'b1;
         col = '0;
         left_bytes = '0;
         upper_left_bytes = '0;
      end else begin
         col = col + 1'b1;
      end
      rebuilt_q.push_back('{pixel_byte: res, last_in_row: last});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rebuilt_q.delete();
         prev_row_valid = 1'b0;
         left_bytes = '0;
         upper_left_bytes = '0;
         col = '0;
         row_filter = FILT_NONE;
         row_bytes_reg = ROW_BYTES_W'(1);
         stride_reg = STRIDE_W'(1);
         failures = 0;
      end else begin
         if (csr_wen) begin
            if (csr_index == CSR_ROW_BYTES) row_bytes_reg = csr_wdata[ROW_BYTES_W-1:0];
            else if (csr_index == CSR_PIXEL_STRIDE) stride_reg = csr_wdata[STRIDE_W-1:0];
         end
         if (req_tvalid && req_tready) take_request(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (rebuilt_q.size() == 0) begin
               $error("unexpected response: pixel_byte %0h last_in_row %0b",
                      rsp_tdata, rsp_tlast);
               failures++;
            end else begin
               due = rebuilt_q.pop_front();
               if (rsp_tdata !== due.pixel_byte) begin
                  $error("pixel_byte mismatch: expected %0h, actual %0h",
                         due.pixel_byte, rsp_tdata);
                  failures++;
               end
               if (rsp_tlast !== due.last_in_row) begin
                  $error("last_in_row mismatch: expected %0b, actual %0b",
                         due.last_in_row, rsp_tlast);
                  failures++;
               end
            end
         end
      end
      pending = rebuilt_q.size();
   end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the png scanline unfilter with directed rows over every filter type
// and then random rows over a range of row lengths and pixel strides, with
// random gaps and stalls on both sides; the checker judges every response.
// ----------------------------------------------------------------------------
module testbench;
   import psu_pkg::*;

   localparam int PHASES = 12;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata;   // byte_value
   logic [REQ_USER_W-1:0] req_tuser;   // is_filter_byte, clear_above
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [BYTE_W-1:0]     rsp_tdata;   // pixel_byte
   logic                  rsp_tlast;
   logic                  csr_wen;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    failures;
   int                    pending;

   bit                    calm;
   bit                    hold_request;
   // shadow of the row memory occupancy, to keep reads inside written entries
   bit                    above_seen;
   int                    row_col;
   int                    row_extent;
   int                    row_len;

   int unsigned phase_rows    [PHASES] = '{1, 0, 5, 16, 12, 7, 24, 3, 33, 64, 9, 4};
   int unsigned phase_strides [PHASES] = '{1, 0, 3, 8, 15, 4, 6, 9, 2, 5, 7, 12};
   int unsigned phase_items   [PHASES] = '{90, 60, 120, 130, 100, 130, 120, 80, 110, 100,
                                           110, 100};

   png_scanline_unfilter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   scanline_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .failures   (failures),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("tb: failure");
      $finish;
   end

   // response side: random back-pressure plus one long hold-off on demand
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 300;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 20);
         end
      end
   end

   function automatic logic [BYTE_W-1:0] pick_byte();
      logic [BYTE_W-1:0] corners [6] = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff};
      if ($urandom_range(3) != 0) return BYTE_W'($urandom_range(255));
      return corners[$urandom_range(5)];
   endfunction

   function automatic logic [BYTE_W-1:0] pick_filter();
      if ($urandom_range(99) < 85) return BYTE_W'($urandom_range(FILT_PAETH, FILT_NONE));
      return BYTE_W'($urandom_range(255, FILT_PAETH + 1));
   endfunction

   task automatic offer(input logic [BYTE_W-1:0] value, input bit is_filter, input bit clr);
      logic [BYTE_W-1:0]     v;
      logic [REQ_USER_W-1:0] u;
      bit                    filt, clear;
      v = value;
      filt = is_filter;
      clear = clr;
      // a data byte past the written part of the row memory becomes a fresh row start
      if (!filt && above_seen && row_col >= row_extent) begin
         v = pick_filter();
         filt = 1'b1;
         clear = 1'b1;
      end
      if (filt) begin
         if (clear) above_seen = 1'b0;
         row_col = 0;
      end else begin
         if (row_col + 1 > row_extent) row_extent = row_col + 1;
         if (row_col + 1 >= row_len) begin
            above_seen = 1'b1;
            row_col = 0;
         end else begin
            row_col++;
         end
      end
      u = '0;
      u[REQ_USER_FILTER] = filt;
      u[REQ_USER_CLEAR] = clear;
      while (!calm && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      req_tuser <= u;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic program_settings(input int unsigned row_value,
                                   input int unsigned stride_value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // filter bytes leave no response behind, so give the pipeline time to drain
      repeat (8) @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= CSR_ROW_BYTES;
      csr_wdata <= CSR_DATA_W'(row_value);
      @(posedge clock);
      csr_index <= CSR_PIXEL_STRIDE;
      csr_wdata <= CSR_DATA_W'(stride_value);
      @(posedge clock);
      csr_wen <= 1'b0;
      row_len = (row_value == 0) ? 1 : ((row_value > MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF
                                                                       : int'(row_value));
   endtask

   task automatic random_stretch(input int budget);
      int sent, roll, count, k;
      sent = 0;
      while (sent < budget) begin
         roll = $urandom_range(99);
         if (roll < 90) begin
            offer(pick_filter(), 1'b1, $urandom_range(9) == 0);
            sent++;
            // full rows mostly, some cut short by the next filter byte
            count = (roll < 80) ? row_len : $urandom_range(row_len - 1);
         end else begin
            count = $urandom_range(row_len, 1);
         end
         for (k = 0; k < count; k++) begin
            offer(pick_byte(), 1'b0, $urandom_range(7) == 0);
            sent++;
         end
      end
   endtask

   initial begin
      int p;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_wen <= 1'b0;
      csr_index <= CSR_ROW_BYTES;
      csr_wdata <= '0;
      reset <= 1'b1;
      calm = 1'b0;
      hold_request = 1'b0;
      above_seen = 1'b0;
      row_col = 0;
      row_extent = 0;
      row_len = 1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // two-byte rows through every filter type
      program_settings(2, 1);
      offer(BYTE_W'(FILT_PAETH), 1'b1, 1'b1);
      offer(8'h00, 1'b0, 1'b0);
      offer(8'hff, 1'b0, 1'b1);    // clear flag on a data byte has no effect
      offer(BYTE_W'(FILT_SUB), 1'b1, 1'b0);
      offer(8'hff, 1'b0, 1'b0);
      offer(8'h01, 1'b0, 1'b0);
      offer(BYTE_W'(FILT_UP), 1'b1, 1'b0);
      offer(8'h80, 1'b0, 1'b0);
      offer(8'h7f, 1'b0, 1'b0);
      offer(BYTE_W'(FILT_AVG), 1'b1, 1'b0);
      offer(8'hff, 1'b0, 1'b0);
      offer(8'hff, 1'b0, 1'b0);
      offer(BYTE_W'(FILT_PAETH), 1'b1, 1'b0);
      offer(8'h10, 1'b0, 1'b0);
      offer(8'hf0, 1'b0, 1'b0);
      offer(8'h05, 1'b1, 1'b0);    // unknown filter code
      offer(8'haa, 1'b0, 1'b0);
      offer(8'h55, 1'b0, 1'b0);
      offer(8'h33, 1'b0, 1'b0);    // row with no filter byte keeps the last type
      offer(8'h44, 1'b0, 1'b0);
      offer(8'hff, 1'b1, 1'b0);
      offer(8'h01, 1'b0, 1'b0);
      offer(BYTE_W'(FILT_PAETH), 1'b1, 1'b0);    // abandons the row half way
      offer(8'h02, 1'b0, 1'b0);
      offer(8'h03, 1'b0, 1'b0);

      for (p = 0; p < PHASES; p++) begin
         program_settings(phase_rows[p], phase_strides[p]);
         if (p == 5) hold_request = 1'b1;
         calm = (p == 8);
         random_stretch(phase_items[p]);
         calm = 1'b0;
      end

      // partial rows with the length register beyond the row memory
      program_settings(16383, 3);
      offer(BYTE_W'(FILT_AVG), 1'b1, 1'b1);
      repeat (48) offer(pick_byte(), 1'b0, 1'b0);
      offer(BYTE_W'(FILT_PAETH), 1'b1, 1'b0);
      repeat (24) offer(pick_byte(), 1'b0, 1'b0);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
